// File: rtl/stable_sorted_priority_queue_assert.svh
// Assertion macros used by the port-level checker of the priority queue.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SSQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SSQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ssq_pkg.sv
// Types and constants of the stable sorted priority queue.
package ssq_pkg;

	localparam int HANDLE_W = 16;
	localparam int PRIO_W   = 2;
	localparam int OCC_W    = 5;
	localparam int STAT_W   = 2;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_REMOVE = 1'b1
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [PRIO_W-1:0] prio;
	} cell_ctrl_t;

endpackage

// File: rtl/ssq_cell.sv
// One storage cell of the sorted queue: holds an entry and shifts with its neighbors.
module ssq_cell import ssq_pkg::*; #(
	parameter int HW = 16
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic              valid,
	input  logic [HW-1:0]     new_handle,
	input  logic              prev_keep,
	input  logic [HW-1:0]     prev_handle,
	input  logic [PRIO_W-1:0] prev_prio,
	input  logic [HW-1:0]     next_handle,
	input  logic [PRIO_W-1:0] next_prio,
	output logic              keep,
	output logic [HW-1:0]     handle,
	output logic [PRIO_W-1:0] prio
);

	logic [HW-1:0]     handle_q;
	logic [PRIO_W-1:0] prio_q;

	assign keep   = valid && (prio_q >= ctrl.prio);
	assign handle = handle_q;
	assign prio   = prio_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && !keep) begin
			if (prev_keep) begin
				handle_q <= new_handle;
				prio_q   <= ctrl.prio;
			end else begin
				handle_q <= prev_handle;
				prio_q   <= prev_prio;
			end
		end else if (ctrl.rem) begin
			handle_q <= next_handle;
			prio_q   <= next_prio;
		end
	end

endmodule

// File: rtl/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue built from a chain of shifting cells.
//
//   channel   direction  tdata fields (low bit up)                      tuser
//   s_axis    in         voter_handle, priority_req                     func
//   m_axis    out        out_handle, out_priority, occupancy            status
//
// Each transaction is handled in the cycle it is accepted; one per cycle is sustained while m_axis_tready is high.
// The cell chain updates in that cycle and the result lands in the output register.
// A new transaction is taken while the output register is empty or being drained.
// Reset empties the queue at once; cell contents are not cleared.
module stable_sorted_priority_queue import ssq_pkg::*; #(
	parameter int DEPTH       = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // voter_handle, priority_req, zero pad
	input  logic                   s_axis_tuser,  // func
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_handle, out_priority, occupancy, zero pad
	output logic [STAT_W-1:0]      m_axis_tuser   // status
);

	localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]         count_q;
	logic                  out_valid_q;
	logic [OUT_TDATA_W-1:0] out_tdata_q;
	status_t               out_status_q;

	logic                  accept;
	logic                  full;
	logic                  empty;
	func_t                 func;
	logic [HW-1:0]         new_handle;
	logic [PRIO_W-1:0]     new_prio;
	cell_ctrl_t            ctrl;

	logic [HW-1:0]         cell_handle [DEPTH];
	logic [PRIO_W-1:0]     cell_prio   [DEPTH];
	logic                  cell_keep   [DEPTH];

	status_t               res_status;
	logic [HANDLE_W-1:0]   res_handle;
	logic [PRIO_W-1:0]     res_prio;
	logic [CW-1:0]         res_count;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign func          = func_t'(s_axis_tuser);
	assign new_handle    = s_axis_tdata[HW-1:0];
	assign new_prio      = s_axis_tdata[HANDLE_W +: PRIO_W];
	assign full          = (count_q == CW'(DEPTH));
	assign empty         = (count_q == '0);

	assign ctrl.ins  = accept && (func == FUNC_INSERT) && !full;
	assign ctrl.rem  = accept && (func == FUNC_REMOVE) && !empty;
	assign ctrl.prio = new_prio;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic              cell_valid;
		logic              prev_keep;
		logic [HW-1:0]     prev_handle;
		logic [PRIO_W-1:0] prev_prio;
		logic [HW-1:0]     next_handle;
		logic [PRIO_W-1:0] next_prio;

		assign cell_valid = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign prev_keep   = 1'b1;
			assign prev_handle = new_handle;
			assign prev_prio   = new_prio;
		end else begin : g_body
			assign prev_keep   = cell_keep[i-1];
			assign prev_handle = cell_handle[i-1];
			assign prev_prio   = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_handle = '0;
			assign next_prio   = '0;
		end else begin : g_link
			assign next_handle = cell_handle[i+1];
			assign next_prio   = cell_prio[i+1];
		end

		ssq_cell #(
			.HW(HW)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.valid       (cell_valid),
			.new_handle  (new_handle),
			.prev_keep   (prev_keep),
			.prev_handle (prev_handle),
			.prev_prio   (prev_prio),
			.next_handle (next_handle),
			.next_prio   (next_prio),
			.keep        (cell_keep[i]),
			.handle      (cell_handle[i]),
			.prio        (cell_prio[i])
		);
	end

	always_comb begin
		res_status = STAT_OK;
		res_handle = '0;
		res_prio   = '0;
		res_count  = count_q;
		if (func == FUNC_INSERT) begin
			if (full) begin
				res_status = STAT_FULL;
			end else begin
				res_count = count_q + CW'(1);
			end
		end else begin
			if (empty) begin
				res_status = STAT_EMPTY;
			end else begin
				res_handle = HANDLE_W'(cell_handle[0]);
				res_prio   = cell_prio[0];
				res_count  = count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= res_count;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= res_status;
			out_tdata_q  <= OUT_TDATA_W'({OCC_W'(res_count), res_prio, res_handle});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_tdata_q;
	assign m_axis_tuser  = out_status_q;

endmodule

// File: rtl/ssq_checker.sv
// Port-level checker of the stable sorted priority queue and its bind.
`include "stable_sorted_priority_queue_assert.svh"

module ssq_checker import ssq_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [STAT_W-1:0]      m_axis_tuser
);

	`SSQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "Result changed while stalled.")
	`SSQ_ASSERT_NEXT(a_accept_result, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "Accepted transaction gave no result.")
	`SSQ_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser == STAT_OK || m_axis_tuser == STAT_FULL || m_axis_tuser == STAT_EMPTY, "Undefined status code.")
	`SSQ_ASSERT_NOW(a_fail_no_data, m_axis_tvalid && m_axis_tuser != STAT_OK, m_axis_tdata[HANDLE_W+PRIO_W-1:0] == '0, "Failed transaction carries an entry.")
	`SSQ_ASSERT_NOW(a_empty_occ, m_axis_tvalid && m_axis_tuser == STAT_EMPTY, m_axis_tdata[HANDLE_W+PRIO_W +: OCC_W] == '0, "Empty status with nonzero occupancy.")

endmodule

bind stable_sorted_priority_queue ssq_checker u_ssq_checker (.*);

// File: verif/stable_sorted_priority_queue_checker.sv
// Checker for the stable sorted priority queue: tracks the queue contents and compares every result.
`timescale 1ns / 100ps

module stable_sorted_priority_queue_checker import ssq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // voter_handle, priority_req, zero pad
	input  logic                   s_axis_tuser,  // func
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_handle, out_priority, occupancy, zero pad
	input  logic [STAT_W-1:0]      m_axis_tuser,  // status
	output int                     mismatch_count,
	output int                     pending_count
);

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
		logic [PRIO_W-1:0]   prio;
		logic [OCC_W-1:0]    occupancy;
	} queue_result_t;

	logic [HANDLE_W-1:0] held_handle [DEPTH];
	logic [PRIO_W-1:0]   held_prio [DEPTH];
	int                  held_count;
	queue_result_t       expected_results [$];

	task automatic apply_queue_op(input func_t op, input logic [HANDLE_W-1:0] handle,
			input logic [PRIO_W-1:0] prio, output queue_result_t res);
		int pos;
		res = '{status: STAT_OK, handle: '0, prio: '0, occupancy: '0};
		if (op == FUNC_INSERT) begin
			if (held_count >= DEPTH) begin
				res.status = STAT_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_prio[pos] >= prio)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					held_handle[i] = held_handle[i-1];
					held_prio[i]   = held_prio[i-1];
				end
				held_handle[pos] = handle;
				held_prio[pos]   = prio;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				res.status = STAT_EMPTY;
			end else begin
				res.handle = held_handle[0];
				res.prio   = held_prio[0];
				for (int i = 1; i < held_count; i++) begin
					held_handle[i-1] = held_handle[i];
					held_prio[i-1]   = held_prio[i];
				end
				held_count--;
			end
		end
		res.occupancy = held_count[OCC_W-1:0];
	endtask

	task automatic check_result(input queue_result_t seen);
		queue_result_t want;
		if (expected_results.size() == 0) begin
			if (mismatch_count < 10)
				$display("%0t: unexpected result status %0d handle %h prio %0d occupancy %0d",
					$realtime, seen.status, seen.handle, seen.prio, seen.occupancy);
			mismatch_count++;
		end else begin
			want = expected_results.pop_front();
			if (seen.status !== want.status || seen.handle !== want.handle ||
					seen.prio !== want.prio || seen.occupancy !== want.occupancy) begin
				if (mismatch_count < 10)
					$display("%0t: mismatch expected status %0d handle %h prio %0d occupancy %0d,",
						$realtime, want.status, want.handle, want.prio, want.occupancy,
						" got status %0d handle %h prio %0d occupancy %0d",
						seen.status, seen.handle, seen.prio, seen.occupancy);
				mismatch_count++;
			end
		end
	endtask

	// Inputs only change at the rising edge, so the falling edge sees what the next rising edge takes.
	always @(negedge clk) begin
		queue_result_t res;
		queue_result_t seen;
		if (!arst_n) begin
			held_count = 0;
			expected_results.delete();
			mismatch_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.status    = status_t'(m_axis_tuser);
				seen.handle    = m_axis_tdata[HANDLE_W-1:0];
				seen.prio      = m_axis_tdata[HANDLE_W +: PRIO_W];
				seen.occupancy = m_axis_tdata[HANDLE_W+PRIO_W +: OCC_W];
				check_result(seen);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				apply_queue_op(func_t'(s_axis_tuser), s_axis_tdata[HANDLE_W-1:0],
					s_axis_tdata[HANDLE_W +: PRIO_W], res);
				expected_results.push_back(res);
			end
		end
		pending_count = expected_results.size();
	end

endmodule

// File: verif/stable_sorted_priority_queue_test.sv
// Testbench top of the stable sorted priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module stable_sorted_priority_queue_test;
	import ssq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_OPS   = 1800;
	localparam int CALM_TAIL    = 200;
	localparam int SEGMENT_OPS  = 60;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = FUNC_INSERT;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b1;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [STAT_W-1:0]      m_axis_tuser;

	int mismatch_count;
	int pending_count;
	bit stalls_on = 1'b0;

	stable_sorted_priority_queue #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	stable_sorted_priority_queue_checker #(
		.DEPTH(DEPTH)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.mismatch_count(mismatch_count),
		.pending_count(pending_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Result side: random stall bursts while stalls are enabled.
	always @(posedge clk) begin
		int stall_left;
		if (!stalls_on) begin
			stall_left = 0;
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(1, 4) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Returns at the rising edge that completes the transaction, with tvalid still high.
	task automatic send_op(input func_t op, input logic [HANDLE_W-1:0] handle,
			input logic [PRIO_W-1:0] prio);
		if (stalls_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {{(IN_TDATA_W-HANDLE_W-PRIO_W){1'b0}}, prio, handle};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
	endtask

	task automatic drain_results;
		do @(posedge clk); while (pending_count != 0);
	endtask

	initial begin
		logic [HANDLE_W-1:0] fill_handles [DEPTH] = '{
			16'h0000, 16'hFFFF, 16'h1234, 16'h0001, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555,
			16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h1111, 16'h2222, 16'h3333, 16'h4444};
		logic [PRIO_W-1:0] fill_prios [DEPTH] = '{
			2'd0, 2'd3, 2'd1, 2'd2, 2'd1, 2'd0, 2'd2, 2'd3,
			2'd1, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd2, 2'd1};
		int insert_pct;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty remove, a full fill with mixed and repeated priorities, a rejected insert, six removes.
		send_op(FUNC_REMOVE, 16'hFFFF, 2'd3);
		for (int i = 0; i < DEPTH; i++)
			send_op(FUNC_INSERT, fill_handles[i], fill_prios[i]);
		send_op(FUNC_INSERT, 16'hDEAD, 2'd3);
		repeat (6) send_op(FUNC_REMOVE, 16'h0000, 2'd0);

		insert_pct = 50;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % SEGMENT_OPS == 0) begin
				case ($urandom_range(0, 2))
					0: insert_pct = 85;
					1: insert_pct = 15;
					default: insert_pct = 50;
				endcase
				stalls_on = (n < RANDOM_OPS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
			end
			if (n == RANDOM_OPS / 2) begin
				s_axis_tvalid <= 1'b0;
				drain_results();
			end
			if ($urandom_range(1, 100) <= insert_pct)
				send_op(FUNC_INSERT, HANDLE_W'($urandom), PRIO_W'($urandom_range(0, 3)));
			else
				send_op(FUNC_REMOVE, HANDLE_W'($urandom), PRIO_W'($urandom_range(0, 3)));
		end
		s_axis_tvalid <= 1'b0;
		drain_results();
		repeat (20) @(posedge clk);

		if (mismatch_count == 0 && pending_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
